/* design/tbha_pkg.sv */
`default_nettype none

package tbha_pkg;

    localparam int NUM_BINS_DEF = 16384;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 14;
    localparam int SAMPLE_W = 16;
    localparam int PTS_W    = 15;
    localparam int OFS_W    = 48;
    localparam int AVG_W    = 24;
    localparam int SERIAL_W = 32;
    localparam int EPOCH_W  = 63;
    localparam int EVENT_W  = 32;
    localparam int TRIG_W   = 40;
    localparam int BIN_W    = 32;
    localparam int INC_W    = AVG_W + 1;

    localparam logic [CMD_W-1:0] CMD_COUNTED  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WAVEFORM = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HIT      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic [IDX_W-1:0]           bin_index;
        logic [SAMPLE_W-1:0]        sample_value;
        logic [PTS_W-1:0]           record_points;
        logic signed [OFS_W-1:0]    offset_ns;
        logic [AVG_W-1:0]           record_averages;
        logic [SERIAL_W-1:0]        record_serial;
        logic [EPOCH_W-1:0]         record_epoch_ns;
        logic [EVENT_W-1:0]         record_events;
    } req_item_t;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_total;
        logic [BIN_W-1:0]    bin_value;
        logic [SERIAL_W-1:0] first_serial;
        logic [SERIAL_W-1:0] last_serial;
        logic [EPOCH_W-1:0]  first_epoch_ns;
        logic [EPOCH_W-1:0]  last_epoch_ns;
        logic [EVENT_W-1:0]  event_flags;
        logic [PTS_W-1:0]    active_points;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic exec;
        logic sweep;
    } tbha_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic needs_clear;
        logic sweep_last;
    } tbha_status_t;

endpackage

`default_nettype wire

/* design/tbha_ctrl.sv */
`default_nettype none

module tbha_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire tbha_pkg::tbha_status_t status,
    output tbha_pkg::tbha_cmd_t        cmd
);
    import tbha_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd.load  = (state_reg == ST_IDLE) && req_valid;
        cmd.rd_en = (state_reg == ST_READ);
        cmd.exec  = (state_reg == ST_EXEC) && !status.out_busy;
        cmd.sweep = (state_reg == ST_CLEAR);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!status.out_busy)
                begin
                    state_next = status.needs_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/tbha_datapath.sv */
`default_nettype none

module tbha_datapath #(
    parameter int NUM_BINS = tbha_pkg::NUM_BINS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tbha_pkg::req_item_t   req_item,
    input  wire tbha_pkg::tbha_cmd_t   cmd,
    output tbha_pkg::tbha_status_t     status,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output tbha_pkg::rsp_item_t        rsp_item
);
    import tbha_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;
    localparam int CW = XW + 1;

    logic [BIN_W-1:0] bin_mem [NUM_BINS];

    req_item_t           item_reg;
    logic [BIN_W-1:0]    rdata_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       clr_addr_next;

    logic [PTS_W-1:0]    points_reg,       points_next;
    logic [OFS_W-1:0]    offset_reg,       offset_next;
    logic [TRIG_W-1:0]   trig_reg,         trig_next;
    logic [SERIAL_W-1:0] serial_first_reg, serial_first_next;
    logic [SERIAL_W-1:0] serial_last_reg,  serial_last_next;
    logic [EPOCH_W-1:0]  epoch_first_reg,  epoch_first_next;
    logic [EPOCH_W-1:0]  epoch_last_reg,   epoch_last_next;
    logic [EVENT_W-1:0]  events_reg,       events_next;
    logic                clear_pend_reg,   clear_pend_next;

    logic                rsp_valid_reg;
    rsp_item_t           rsp_item_reg;
    rsp_item_t           rsp_item_next;

    logic [XW-1:0]       idx_x;
    logic [AW-1:0]       bin_addr;
    logic                bin_ok;
    logic                is_header;
    logic                counted;
    logic                do_clear;
    logic [INC_W-1:0]    inc;
    logic [TRIG_W-1:0]   trig_base;
    logic [TRIG_W:0]     trig_sum;
    logic [BIN_W:0]      sample_sum;
    logic [BIN_W-1:0]    readback;
    logic                mem_wr;
    logic [AW-1:0]       mem_wr_addr;
    logic [BIN_W-1:0]    mem_wr_data;

    assign idx_x    = XW'(item_reg.bin_index);
    assign bin_addr = idx_x[AW-1:0];
    assign bin_ok   = ({1'b0, item_reg.bin_index} < points_reg)
                      && (CW'(item_reg.bin_index) < CW'(NUM_BINS));

    assign counted   = (item_reg.command == CMD_COUNTED);
    assign is_header = counted || (item_reg.command == CMD_WAVEFORM);
    assign do_clear  = clear_pend_reg
                       || (counted && ((points_reg != item_reg.record_points)
                                       || (offset_reg != item_reg.offset_ns)));

    always_comb
    begin
        if (counted)
        begin
            inc = INC_W'(item_reg.record_averages) + INC_W'(1);
        end
        else if (item_reg.record_averages == '0)
        begin
            inc = INC_W'(1);
        end
        else
        begin
            inc = INC_W'(item_reg.record_averages);
        end
    end

    assign trig_base  = do_clear ? TRIG_W'(inc) : trig_reg;
    assign trig_sum   = {1'b0, trig_base} + (TRIG_W + 1)'(inc);
    assign sample_sum = {1'b0, rdata_reg} + (BIN_W + 1)'(item_reg.sample_value);

    always_comb
    begin
        points_next       = points_reg;
        offset_next       = offset_reg;
        trig_next         = trig_reg;
        serial_first_next = serial_first_reg;
        serial_last_next  = serial_last_reg;
        epoch_first_next  = epoch_first_reg;
        epoch_last_next   = epoch_last_reg;
        events_next       = events_reg;
        clear_pend_next   = clear_pend_reg;
        readback          = '0;
        mem_wr            = 1'b0;
        mem_wr_addr       = bin_addr;
        mem_wr_data       = rdata_reg;

        case (item_reg.command)
            CMD_COUNTED, CMD_WAVEFORM:
            begin
                if (do_clear)
                begin
                    points_next       = item_reg.record_points;
                    offset_next       = item_reg.offset_ns;
                    serial_first_next = item_reg.record_serial;
                    epoch_first_next  = item_reg.record_epoch_ns;
                    clear_pend_next   = 1'b0;
                end
                trig_next        = trig_sum[TRIG_W] ? '1 : trig_sum[TRIG_W-1:0];
                serial_last_next = item_reg.record_serial;
                epoch_last_next  = item_reg.record_epoch_ns;
                events_next      = (do_clear ? '0 : events_reg) | item_reg.record_events;
            end
            CMD_HIT:
            begin
                if (bin_ok && (rdata_reg != '1))
                begin
                    mem_wr      = 1'b1;
                    mem_wr_data = rdata_reg + BIN_W'(1);
                end
            end
            CMD_SAMPLE:
            begin
                if (bin_ok)
                begin
                    mem_wr      = 1'b1;
                    mem_wr_data = sample_sum[BIN_W] ? '1 : sample_sum[BIN_W-1:0];
                end
            end
            CMD_READ:
            begin
                if (bin_ok)
                begin
                    readback = rdata_reg;
                end
            end
            CMD_CLEAR:
            begin
                clear_pend_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (cmd.sweep)
        begin
            mem_wr      = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = '0;
        end
        else if (!cmd.exec)
        begin
            mem_wr = 1'b0;
        end
    end

    always_comb
    begin
        rsp_item_next.trigger_total  = trig_next;
        rsp_item_next.bin_value      = readback;
        rsp_item_next.first_serial   = serial_first_next;
        rsp_item_next.last_serial    = serial_last_next;
        rsp_item_next.first_epoch_ns = epoch_first_next;
        rsp_item_next.last_epoch_ns  = epoch_last_next;
        rsp_item_next.event_flags    = events_next;
        rsp_item_next.active_points  = points_next;
    end

    assign status.out_busy    = rsp_valid_reg && rsp_stall;
    assign status.needs_clear = is_header && do_clear;
    assign status.sweep_last  = (clr_addr_reg == AW'(NUM_BINS - 1));

    assign clr_addr_next = status.sweep_last ? '0 : clr_addr_reg + AW'(1);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            bin_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= bin_mem[bin_addr];
        end
        if (cmd.load)
        begin
            item_reg <= req_item;
        end
        if (cmd.exec)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            points_reg       <= '0;
            offset_reg       <= '0;
            trig_reg         <= '0;
            serial_first_reg <= '0;
            serial_last_reg  <= '0;
            epoch_first_reg  <= '0;
            epoch_last_reg   <= '0;
            events_reg       <= '0;
            clear_pend_reg   <= 1'b1;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            if (cmd.exec)
            begin
                points_reg       <= points_next;
                offset_reg       <= offset_next;
                trig_reg         <= trig_next;
                serial_first_reg <= serial_first_next;
                serial_last_reg  <= serial_last_next;
                epoch_first_reg  <= epoch_first_next;
                epoch_last_reg   <= epoch_last_next;
                events_reg       <= events_next;
                clear_pend_reg   <= clear_pend_next;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/time_bin_histogram_accumulator.sv */
// Channel   Valid       Stall       Payload    Direction
// request   req_valid   req_stall   req_item   into the block
// response  rsp_valid   rsp_stall   rsp_item   out of the block
//
// Every item passes the steps latch, bin store read, then update and result.
// A header that clears the bins is followed by a sweep that zeroes all NUM_BINS bins
// through the single write port of the bin store, and reset starts the same sweep.
// The request side is stalled during the sweep and while an item is at work.
// A held result holds the update step, and the request side stays stalled until it is taken.
`default_nettype none

module time_bin_histogram_accumulator #(
    parameter int NUM_BINS = tbha_pkg::NUM_BINS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire tbha_pkg::req_item_t req_item,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output tbha_pkg::rsp_item_t      rsp_item
);
    import tbha_pkg::*;

    tbha_cmd_t    cmd;
    tbha_status_t status;

    tbha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tbha_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire
